### rtl/cdp_pkg.sv
// Shared types and constants for the clock divider planner.
// No dependencies; used by cdp_div and clock_divider_planner.
package cdp_pkg;

    localparam int REQ_W     = 32;
    localparam int CLK_W     = 26;
    localparam int F_W       = 12;
    localparam int HALF_W    = 17;
    localparam int NUM_W     = 34;
    localparam int DEN_W     = 26;
    localparam int DIV_STEPS = NUM_W;

    localparam logic [1:0] ROUTE_OFF   = 2'd0;
    localparam logic [1:0] ROUTE_TIMER = 2'd1;
    localparam logic [1:0] ROUTE_SYNTH = 2'd2;

    localparam logic [REQ_W-1:0]  TIMER_LIMIT   = 32'd400000;
    localparam logic [F_W-1:0]    FAST_MIN_HZ   = 12'd122;
    localparam logic [HALF_W-1:0] MAX_HALF      = 17'h10000;
    localparam logic [CLK_W-1:0]  CLK_RESET     = 26'd16000000;
    localparam logic [6:0]        CENTI_PER_HZ  = 7'd100;
    // floor(x / 100) = (x * 335545) >> 25 for x below 493499
    localparam logic [18:0]       DIV100_MUL    = 19'd335545;
    localparam int                DIV100_SHIFT  = 25;

    typedef struct packed {
        logic [1:0]        route;
        logic              slow;
        logic              fzero;
        logic [REQ_W-1:0]  req;
        logic [CLK_W-1:0]  clk;
        logic [F_W-1:0]    f;
        logic [CLK_W-1:0]  lo;
        logic [CLK_W-1:0]  hi;
        logic [HALF_W-1:0] half;
    } t_ctx;

endpackage

### rtl/clock_divider_planner.sv
// Clock divider planner: frequency request in, timer/synthesizer plan out.
// Stages: one front stage, three 34-step divider pipelines
// (clk/f, clk/lo with clk/hi in parallel, clk*100/(2*half)), two select
// stages and the output register. Throughput one transfer per cycle; a
// stall freezes the whole pipeline. Synchronous active-low reset clears
// valid bits and sets fast_clock_hz to 16000000. Depends on cdp_pkg, cdp_div.
module clock_divider_planner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_request_centi_hz,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_route,
    output logic        o_slow_clock_used,
    output logic [15:0] o_compare_value,
    output logic [31:0] o_achieved_centi_hz,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [cdp_pkg::CLK_W-1:0] r_fast_hz;
    logic                      en;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_hz <= cdp_pkg::CLK_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_fast_hz <= pwdata[cdp_pkg::CLK_W-1:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {6'd0, r_fast_hz};

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // front stage: f = req / 100, route and clock choice
    logic          r_a_vld;
    cdp_pkg::t_ctx r_a_ctx;
    cdp_pkg::t_ctx n_a_ctx;
    logic [37:0]   prod100;

    always_comb begin
        prod100 = 38'(i_request_centi_hz[18:0]) * 38'(cdp_pkg::DIV100_MUL);
        n_a_ctx       = '0;
        n_a_ctx.req   = i_request_centi_hz;
        n_a_ctx.f     = prod100[cdp_pkg::DIV100_SHIFT +: cdp_pkg::F_W];
        n_a_ctx.fzero = (n_a_ctx.f == '0);
        if (i_request_centi_hz == '0) begin
            n_a_ctx.route = cdp_pkg::ROUTE_OFF;
        end else if (i_request_centi_hz <= cdp_pkg::TIMER_LIMIT) begin
            n_a_ctx.route = cdp_pkg::ROUTE_TIMER;
        end else begin
            n_a_ctx.route = cdp_pkg::ROUTE_SYNTH;
        end
        n_a_ctx.slow = (n_a_ctx.f <= cdp_pkg::FAST_MIN_HZ);
        n_a_ctx.clk  = n_a_ctx.slow ? {4'd0, r_fast_hz[cdp_pkg::CLK_W-1:4]} : r_fast_hz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ctx <= n_a_ctx;
        end
    end

    // q = clk / f
    logic                      d1_vld;
    logic [cdp_pkg::NUM_W-1:0] d1_quot;
    cdp_pkg::t_ctx             d1_ctx;

    cdp_div u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_vld),
        .i_num   ({8'd0, r_a_ctx.clk}),
        .i_den   ({14'd0, r_a_ctx.f}),
        .i_ctx   (r_a_ctx),
        .o_valid (d1_vld),
        .o_quot  (d1_quot),
        .o_ctx   (d1_ctx)
    );

    // candidate half periods
    logic          r_b_vld;
    cdp_pkg::t_ctx r_b_ctx;
    cdp_pkg::t_ctx n_b_ctx;
    logic [cdp_pkg::CLK_W:0] q_inc;

    always_comb begin
        q_inc      = {1'b0, d1_quot[cdp_pkg::CLK_W-1:0]} + 1'b1;
        n_b_ctx    = d1_ctx;
        n_b_ctx.lo = {1'b0, d1_quot[cdp_pkg::CLK_W-1:1]};
        n_b_ctx.hi = q_inc[cdp_pkg::CLK_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= d1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ctx <= n_b_ctx;
        end
    end

    // clk / lo and clk / hi side by side
    logic                      d2_vld;
    logic [cdp_pkg::NUM_W-1:0] d2_quot;
    cdp_pkg::t_ctx             d2_ctx;
    logic [cdp_pkg::NUM_W-1:0] d3_quot;

    cdp_div u_div_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_vld),
        .i_num   ({8'd0, r_b_ctx.clk}),
        .i_den   (r_b_ctx.lo),
        .i_ctx   (r_b_ctx),
        .o_valid (d2_vld),
        .o_quot  (d2_quot),
        .o_ctx   (d2_ctx)
    );

    cdp_div u_div_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_vld),
        .i_num   ({8'd0, r_b_ctx.clk}),
        .i_den   (r_b_ctx.hi),
        .i_ctx   (r_b_ctx),
        .o_valid (),
        .o_quot  (d3_quot),
        .o_ctx   ()
    );

    // nearest choice, clamp, achieved-frequency operands
    logic                      r_c_vld;
    cdp_pkg::t_ctx             r_c_ctx;
    logic [32:0]               r_c_num;
    cdp_pkg::t_ctx             n_c_ctx;
    logic [cdp_pkg::CLK_W-1:0] target;
    logic [cdp_pkg::CLK_W-1:0] f_lo;
    logic [cdp_pkg::CLK_W-1:0] f_hi;
    logic [cdp_pkg::CLK_W-1:0] d_lo;
    logic [cdp_pkg::CLK_W-1:0] d_hi;
    logic [cdp_pkg::CLK_W-1:0] pick;
    logic [33:0]               clk100;

    always_comb begin
        target = {13'd0, d2_ctx.f, 1'b0};
        f_lo   = d2_quot[cdp_pkg::CLK_W-1:0];
        f_hi   = d3_quot[cdp_pkg::CLK_W-1:0];
        d_lo   = (f_lo >= target) ? (f_lo - target) : (target - f_lo);
        d_hi   = (target >= f_hi) ? (target - f_hi) : (f_hi - target);
        pick   = (d_lo <= d_hi) ? d2_ctx.lo : d2_ctx.hi;
        n_c_ctx = d2_ctx;
        if (d2_ctx.fzero) begin
            n_c_ctx.half = cdp_pkg::MAX_HALF;
        end else if (d2_ctx.lo == '0) begin
            n_c_ctx.half = 17'd1;
        end else if (pick > cdp_pkg::CLK_W'(cdp_pkg::MAX_HALF)) begin
            n_c_ctx.half = cdp_pkg::MAX_HALF;
        end else begin
            n_c_ctx.half = pick[cdp_pkg::HALF_W-1:0];
        end
        clk100 = 34'(d2_ctx.clk) * 34'(cdp_pkg::CENTI_PER_HZ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= d2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ctx <= n_c_ctx;
            r_c_num <= clk100[32:0];
        end
    end

    // achieved = clk * 100 / (2 * half)
    logic                      d4_vld;
    logic [cdp_pkg::NUM_W-1:0] d4_quot;
    cdp_pkg::t_ctx             d4_ctx;

    cdp_div u_div_ach (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_num   ({1'b0, r_c_num}),
        .i_den   ({8'd0, r_c_ctx.half, 1'b0}),
        .i_ctx   (r_c_ctx),
        .o_valid (d4_vld),
        .o_quot  (d4_quot),
        .o_ctx   (d4_ctx)
    );

    // output register
    logic        r_o_vld;
    logic [1:0]  r_route;
    logic        r_slow;
    logic [15:0] r_cmp;
    logic [31:0] r_ach;
    logic        n_slow;
    logic [15:0] n_cmp;
    logic [31:0] n_ach;
    logic [cdp_pkg::HALF_W-1:0] half_m1;

    always_comb begin
        half_m1 = d4_ctx.half - 1'b1;
        n_slow  = 1'b0;
        n_cmp   = '0;
        n_ach   = '0;
        case (d4_ctx.route)
            cdp_pkg::ROUTE_TIMER: begin
                n_slow = d4_ctx.slow;
                n_cmp  = half_m1[15:0];
                n_ach  = d4_quot[31:0];
            end
            cdp_pkg::ROUTE_SYNTH: begin
                n_ach = d4_ctx.req;
            end
            default: begin
                n_ach = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= d4_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_route <= d4_ctx.route;
            r_slow  <= n_slow;
            r_cmp   <= n_cmp;
            r_ach   <= n_ach;
        end
    end

    assign o_valid             = r_o_vld;
    assign o_route             = r_route;
    assign o_slow_clock_used   = r_slow;
    assign o_compare_value     = r_cmp;
    assign o_achieved_centi_hz = r_ach;

endmodule

### rtl/cdp_div.sv
// Pipelined restoring divider, one quotient bit per stage, context carried alongside.
// Depends on cdp_pkg.
module cdp_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [cdp_pkg::NUM_W-1:0] i_num,
    input  logic [cdp_pkg::DEN_W-1:0] i_den,
    input  cdp_pkg::t_ctx           i_ctx,
    output logic                    o_valid,
    output logic [cdp_pkg::NUM_W-1:0] o_quot,
    output cdp_pkg::t_ctx           o_ctx
);

    logic                        r_vld [cdp_pkg::DIV_STEPS];
    logic [cdp_pkg::DEN_W-1:0]   r_rem [cdp_pkg::DIV_STEPS];
    logic [cdp_pkg::NUM_W-1:0]   r_num [cdp_pkg::DIV_STEPS];
    logic [cdp_pkg::DEN_W-1:0]   r_den [cdp_pkg::DIV_STEPS];
    cdp_pkg::t_ctx               r_ctx [cdp_pkg::DIV_STEPS];

    logic                        n_vld [cdp_pkg::DIV_STEPS];
    logic [cdp_pkg::DEN_W-1:0]   n_rem [cdp_pkg::DIV_STEPS];
    logic [cdp_pkg::NUM_W-1:0]   n_num [cdp_pkg::DIV_STEPS];
    logic [cdp_pkg::DEN_W-1:0]   n_den [cdp_pkg::DIV_STEPS];
    cdp_pkg::t_ctx               n_ctx [cdp_pkg::DIV_STEPS];

    always_comb begin
        logic [cdp_pkg::DEN_W-1:0] s_rem;
        logic [cdp_pkg::NUM_W-1:0] s_num;
        logic [cdp_pkg::DEN_W-1:0] s_den;
        logic [cdp_pkg::DEN_W:0]   trial;
        logic                      qbit;
        for (int s = 0; s < cdp_pkg::DIV_STEPS; s++) begin
            if (s == 0) begin
                s_rem    = '0;
                s_num    = i_num;
                s_den    = i_den;
                n_vld[s] = i_valid;
                n_ctx[s] = i_ctx;
            end else begin
                s_rem    = r_rem[s-1];
                s_num    = r_num[s-1];
                s_den    = r_den[s-1];
                n_vld[s] = r_vld[s-1];
                n_ctx[s] = r_ctx[s-1];
            end
            trial = {s_rem, s_num[cdp_pkg::NUM_W-1]};
            qbit  = (trial >= {1'b0, s_den});
            if (qbit) begin
                n_rem[s] = cdp_pkg::DEN_W'(trial - {1'b0, s_den});
            end else begin
                n_rem[s] = trial[cdp_pkg::DEN_W-1:0];
            end
            n_num[s] = {s_num[cdp_pkg::NUM_W-2:0], qbit};
            n_den[s] = s_den;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < cdp_pkg::DIV_STEPS; s++) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= n_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < cdp_pkg::DIV_STEPS; s++) begin
                r_rem[s] <= n_rem[s];
                r_num[s] <= n_num[s];
                r_den[s] <= n_den[s];
                r_ctx[s] <= n_ctx[s];
            end
        end
    end

    assign o_valid = r_vld[cdp_pkg::DIV_STEPS-1];
    assign o_quot  = r_num[cdp_pkg::DIV_STEPS-1];
    assign o_ctx   = r_ctx[cdp_pkg::DIV_STEPS-1];

endmodule

### sim/clock_divider_planner_tb.sv
// Self-checking testbench for clock_divider_planner: drives frequency requests,
// predicts each timer/synthesizer plan and compares every transfer.
// Depends on cdp_pkg and the clock_divider_planner RTL.
`timescale 1ns / 1ps

module clock_divider_planner_tb;

    typedef struct packed {
        logic [1:0]  route;
        logic        slow;
        logic [15:0] cmp;
        logic [31:0] achieved;
    } t_plan;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_request_centi_hz = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_route;
    logic        o_slow_clock_used;
    logic [15:0] o_compare_value;
    logic [31:0] o_achieved_centi_hz;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    localparam logic [2:0] ADDR_FAST_CLOCK = 3'd0;
    localparam int LATENCY   = 106;
    localparam int WDOG_MAX  = 20000;

    t_plan       plans_due[$];
    logic [25:0] fast_clock_hz = cdp_pkg::CLK_RESET;
    int          errors = 0;
    int          idle_pct_in = 20;
    int          idle_pct_out = 20;
    int          hold_off = 0;
    int          wdog = 0;

    clock_divider_planner dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] abs_gap(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic t_plan plan_request(input logic [31:0] req);
        t_plan       p;
        logic [63:0] f, clk, half, q, lo, hi, tgt;
        p = '0;
        if (req == 0) begin
            p.route = cdp_pkg::ROUTE_OFF;
        end else if (req <= cdp_pkg::TIMER_LIMIT) begin
            p.route = cdp_pkg::ROUTE_TIMER;
            f = req / 100;
            if (f > 122) begin
                clk = fast_clock_hz;
            end else begin
                clk = fast_clock_hz / 16;
                p.slow = 1'b1;
            end
            if (f == 0) begin
                half = 64'h10000;
            end else begin
                q  = clk / f;
                lo = q / 2;
                hi = (q + 1) / 2;
                if (lo == 0) begin
                    half = 1;
                end else begin
                    tgt  = 2 * f;
                    half = (abs_gap(clk / lo, tgt) <= abs_gap(tgt, clk / hi)) ? lo : hi;
                    if (half > 64'h10000) half = 64'h10000;
                end
            end
            p.cmp      = 16'(half - 1);
            p.achieved = 32'((clk * 100) / (2 * half));
        end else begin
            p.route    = cdp_pkg::ROUTE_SYNTH;
            p.achieved = req;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result side: random ready, long hold-off on request, checks each transfer
    always @(posedge i_clk) begin
        t_plan want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (plans_due.size() == 0) begin
                    report_mismatch("unexpected transfer", o_route, 0);
                end else begin
                    want = plans_due.pop_front();
                    if (o_route != want.route)
                        report_mismatch("route", o_route, want.route);
                    if (o_slow_clock_used != want.slow)
                        report_mismatch("slow_clock_used", o_slow_clock_used, want.slow);
                    if (o_compare_value != want.cmp)
                        report_mismatch("compare_value", o_compare_value, want.cmp);
                    if (o_achieved_centi_hz != want.achieved)
                        report_mismatch("achieved", o_achieved_centi_hz, want.achieved);
                end
            end
            wdog <= ((o_valid && i_ready) || (i_valid && o_ready)) ? 0 : wdog + 1;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_pct_out);
        end
    end

    always @(posedge i_clk) begin
        if (wdog >= WDOG_MAX) begin
            $display("clock_divider_planner_tb: FAIL");
            $finish;
        end
    end

    // entered and left at a falling edge; valid stays up into the next request
    task automatic send_request(input logic [31:0] req);
        while ($urandom_range(99) < idle_pct_in) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_request_centi_hz <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        plans_due.push_back(plan_request(req));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (plans_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_fast_clock(input logic [25:0] hz);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_FAST_CLOCK; pwdata <= 32'(hz);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        fast_clock_hz = hz;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] random_request();
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(99);
            2:       return $urandom_range(12300);
            3:       return $urandom_range(12400, 12200);
            4:       return $urandom_range(400000, 399000);
            5:       return $urandom;
            default: return $urandom_range(400000);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] reqs[$] = '{0, 1, 99, 100, 12299, 12300, 12399, 12400, 50000,
                                 123456, 399999, 400000, 400001, 32'hFFFF_FFFF,
                                 32'h5555_5555, 32'hAAAA_AAAA, 7777, 250};
        foreach (reqs[i]) send_request(reqs[i]);
    endtask

    task automatic test_random(input int n);
        repeat (n) send_request(random_request());
    endtask

    task automatic test_no_idle(input int n);
        idle_pct_in = 0; idle_pct_out = 0;
        test_random(n);
        idle_pct_in = 20; idle_pct_out = 20;
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        test_random(150);
    endtask

    task automatic test_clock_settings();
        logic [25:0] clocks[$] = '{26'd1000000, 26'd64000000, 26'h3FFFFFF, 26'd0,
                                   26'd15, 26'd12345678};
        foreach (clocks[i]) begin
            drain();
            write_fast_clock(clocks[i]);
            test_directed();
            test_random(10);
        end
        drain();
        write_fast_clock(cdp_pkg::CLK_RESET);
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(80);
        test_no_idle(100);
        test_backpressure();
        test_clock_settings();
        drain();
        if (errors == 0) begin
            $display("clock_divider_planner_tb: PASS");
        end else begin
            $display("clock_divider_planner_tb: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/cdp_pkg.sv
rtl/cdp_div.sv
rtl/clock_divider_planner.sv
sim/clock_divider_planner_tb.sv
